### rtl/core/fvl_pkg.sv
// ----------------------------------------------------------------------------
// fvl_pkg
// Shared types, constants and helpers for the float vector length block.
// ----------------------------------------------------------------------------
package fvl_pkg;

    localparam int MAX_LANES = 4;
    // register stages from input acceptance to the result register
    localparam int STAGES      = 22;
    localparam int ROOT_STAGES = 15;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    // positive double-precision value: sig has its top bit set, exp is the
    // unbiased exponent of that top bit
    typedef struct packed {
        logic               zero;
        logic signed [10:0] exp;
        logic [52:0]        sig;
    } dbl_t;

    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_NAN,
        SPEC_INF
    } spec_t;

    // leading zero count of a 24-bit word
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/fvl_lane.sv
// ----------------------------------------------------------------------------
// fvl_lane
// Squares one binary32 magnitude exactly and presents it as a double.
// ----------------------------------------------------------------------------
module fvl_lane import fvl_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] comp,
    output dbl_t        sq
);

    logic [7:0]         e_fld;
    logic [22:0]        f_fld;
    logic [23:0]        m_raw;
    logic [4:0]         lz;
    logic [23:0]        m_norm;
    logic signed [9:0]  e_norm;
    logic               is_zero;

    logic [47:0]        p_reg;
    logic signed [9:0]  e_reg;
    logic               zero_reg;

    always_comb begin
        e_fld   = comp[30:23];
        f_fld   = comp[22:0];
        m_raw   = (e_fld != 8'd0) ? {1'b1, f_fld} : {1'b0, f_fld};
        lz      = lzc24(m_raw);
        m_norm  = m_raw << lz;
        // subnormals sit at the minimum exponent
        e_norm  = ((e_fld != 8'd0) ? ($signed({2'b00, e_fld}) - 10'sd127) : -10'sd126)
                  - $signed({5'd0, lz});
        is_zero = (e_fld == 8'd0) && (f_fld == 23'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= m_norm * m_norm;
            e_reg    <= e_norm;
            zero_reg <= is_zero;
        end
    end

    always_comb begin
        sq.zero = zero_reg;
        if (p_reg[47]) begin
            sq.exp = {e_reg, 1'b1};
            sq.sig = {p_reg, 5'd0};
        end else begin
            sq.exp = {e_reg, 1'b0};
            sq.sig = {p_reg[46:0], 6'd0};
        end
    end

endmodule

### rtl/core/fvl_dadd.sv
// ----------------------------------------------------------------------------
// fvl_dadd
// Two-stage double adder for positive operands, round to nearest even.
// ----------------------------------------------------------------------------
module fvl_dadd import fvl_pkg::*; (
    input  logic aclk,
    input  logic en_a,
    input  logic en_b,
    input  dbl_t a,
    input  dbl_t b,
    input  logic use_b,
    output dbl_t y
);

    // alignment
    logic               a_big;
    dbl_t               big;
    dbl_t               small_op;
    logic signed [11:0] diff;
    logic [5:0]         dcap;
    logic [110:0]       ext;
    logic [55:0]        op;

    dbl_t               big_reg;
    logic [55:0]        op_reg;

    // add and round
    logic [56:0]        s;
    logic [52:0]        kept;
    logic               g;
    logic               st;
    logic signed [10:0] ex;
    logic [53:0]        r;

    always_comb begin
        a_big    = (a.exp >= b.exp);
        big      = a_big ? a : b;
        small_op = a_big ? b : a;
        diff     = $signed({big.exp[10], big.exp}) - $signed({small_op.exp[10], small_op.exp});
        dcap     = (diff > 12'sd63) ? 6'd63 : diff[5:0];
        ext      = {small_op.sig, 58'd0} >> dcap;
        if (diff > 12'sd63) begin
            op = 56'd1;
        end else begin
            op = {ext[110:56], |ext[55:0]};
        end
        if (b.zero || !use_b) begin
            big = a;
            op  = 56'd0;
        end else if (a.zero) begin
            big = b;
            op  = 56'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            big_reg <= big;
            op_reg  <= op;
        end
    end

    always_comb begin
        s = {1'b0, big_reg.sig, 3'd0} + {1'b0, op_reg};
        if (s[56]) begin
            kept = s[56:4];
            g    = s[3];
            st   = |s[2:0];
            ex   = big_reg.exp + 11'sd1;
        end else begin
            kept = s[55:3];
            g    = s[2];
            st   = |s[1:0];
            ex   = big_reg.exp;
        end
        r = {1'b0, kept} + {53'd0, g && (st || kept[0])};
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            y.zero <= big_reg.zero;
            if (r[53]) begin
                y.sig <= r[53:1];
                y.exp <= ex + 11'sd1;
            end else begin
                y.sig <= r[52:0];
                y.exp <= ex;
            end
        end
    end

endmodule

### rtl/core/fvl_root.sv
// ----------------------------------------------------------------------------
// fvl_root
// Rounds the double sum to binary32, then takes a pipelined square root,
// two result bits per stage, and packs the final result.
// ----------------------------------------------------------------------------
module fvl_root import fvl_pkg::*; (
    input  logic                   aclk,
    input  logic [ROOT_STAGES-1:0] en,
    input  dbl_t                   x,
    input  spec_t                  spec,
    output logic [31:0]            y
);

    localparam int ITERS = 12;

    typedef enum logic [1:0] {
        K_NUM,
        K_ZERO,
        K_INF,
        K_NAN
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ebase;
        logic [47:0] n;
        logic [25:0] rem;
        logic [23:0] root;
    } it_t;

    function automatic it_t sqrt_step(input it_t s);
        it_t         o;
        logic [27:0] r3;
        logic [25:0] t;
        o    = s;
        r3   = {s.rem, s.n[47:46]};
        t    = {s.root, 2'b01};
        o.n  = {s.n[45:0], 2'b00};
        if (r3 >= {2'b00, t}) begin
            o.rem  = 26'(r3 - {2'b00, t});
            o.root = {s.root[22:0], 1'b1};
        end else begin
            o.rem  = r3[25:0];
            o.root = {s.root[22:0], 1'b0};
        end
        return o;
    endfunction

    // ---- round double to binary32 ----
    logic signed [11:0] fe;
    logic               normal;
    logic               tiny;
    logic [5:0]         sh;
    logic [116:0]       rext;
    logic [23:0]        mant;
    logic [24:0]        mr;
    logic [9:0]         ebits;
    logic [32:0]        total;
    logic [30:0]        fbits;

    logic [30:0]        fbits_reg;
    spec_t              spec_reg;

    always_comb begin
        fe     = $signed({x.exp[10], x.exp}) + 12'sd127;
        normal = (fe >= 12'sd1);
        tiny   = (fe < -12'sd33);
        sh     = normal ? 6'd29 : 6'(12'sd30 - fe);
        rext   = {x.sig, 64'd0} >> sh;
        mant   = rext[87:64];
        mr     = {1'b0, mant} + {24'd0, rext[63] && ((|rext[62:0]) || mant[0])};
        ebits  = normal ? 10'(fe - 12'sd1) : 10'd0;
        total  = {ebits, 23'd0} + {8'd0, mr};
        if (x.zero || (!normal && tiny)) begin
            fbits = 31'd0;
        end else if (total >= {1'b0, INF_BITS}) begin
            fbits = INF_BITS[30:0];
        end else begin
            fbits = total[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            fbits_reg <= fbits;
            spec_reg  <= spec;
        end
    end

    // ---- root set-up: normalise, make the exponent even ----
    logic [7:0]        pe;
    logic [23:0]       pm_raw;
    logic [4:0]        plz;
    logic [23:0]       pm;
    logic signed [9:0] pex;
    logic signed [9:0] pex2;
    logic signed [9:0] ph;
    it_t               prep;

    it_t               it_reg [0:ITERS];

    always_comb begin
        pe     = fbits_reg[30:23];
        pm_raw = (pe != 8'd0) ? {1'b1, fbits_reg[22:0]} : {1'b0, fbits_reg[22:0]};
        plz    = lzc24(pm_raw);
        pm     = pm_raw << plz;
        pex    = ((pe != 8'd0) ? ($signed({2'b00, pe}) - 10'sd150) : -10'sd149)
                 - $signed({5'd0, plz});
        pex2   = pex[0] ? (pex - 10'sd23) : (pex - 10'sd24);
        ph     = pex2 >>> 1;
        prep.ebase = 8'(ph + 10'sd150);
        prep.n     = pex[0] ? {1'b0, pm, 23'd0} : {pm, 24'd0};
        prep.rem   = 26'd0;
        prep.root  = 24'd0;
        priority if (spec_reg == SPEC_NAN) begin
            prep.kind = K_NAN;
        end else if (spec_reg == SPEC_INF || pe == 8'hFF) begin
            prep.kind = K_INF;
        end else if (fbits_reg == 31'd0) begin
            prep.kind = K_ZERO;
        end else begin
            prep.kind = K_NUM;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            it_reg[0] <= prep;
        end
    end

    for (genvar k = 1; k <= ITERS; k++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                it_reg[k] <= sqrt_step(sqrt_step(it_reg[k-1]));
            end
        end
    end

    // ---- pack: round up when the remainder exceeds the root ----
    it_t         fin;
    logic [24:0] r1;
    logic [31:0] packed_bits;

    always_comb begin
        fin         = it_reg[ITERS];
        r1          = {1'b0, fin.root} + {24'd0, (fin.rem > {2'b00, fin.root})};
        packed_bits = {1'b0, 8'(fin.ebase - 8'd1), 23'd0} + {7'd0, r1};
    end

    always_ff @(posedge aclk) begin
        if (en[ROOT_STAGES-1]) begin
            unique case (fin.kind)
                K_NUM:   y <= packed_bits;
                K_ZERO:  y <= 32'd0;
                K_INF:   y <= INF_BITS;
                K_NAN:   y <= QNAN_BITS;
                default: y <= QNAN_BITS;
            endcase
        end
    end

endmodule

### rtl/core/float_vector_length.sv
// ----------------------------------------------------------------------------
// float_vector_length
// Euclidean length of a vector of one to four binary32 components.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  input   | s_valid s_ready s_comp_x/y/z/w s_lane_count  | in
//  result  | m_valid m_ready m_length_bits                | out
//
//  One item per cycle sustained while m_ready is high; 22 register stages
//  (square, three two-stage double adds, binary32 rounding, root set-up,
//  twelve two-bit root stages, pack), the last of which is the result
//  register that m_valid and m_length_bits come from.
//  Each stage holds its own valid bit, so bubbles close up and new items
//  are taken while a finished result waits on m_ready.
//  aresetn is synchronous and clears only the stage valid bits.
// ----------------------------------------------------------------------------
module float_vector_length import fvl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_comp_x,
    input  logic [31:0] s_comp_y,
    input  logic [31:0] s_comp_z,
    input  logic [31:0] s_comp_w,
    input  logic [2:0]  s_lane_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_length_bits
);

    localparam int SIDE_DEPTH = 7;

    typedef struct packed {
        spec_t      spec;
        logic [3:1] act;
    } side_t;

    // ---- stage handshake: a stage loads when empty or when it moves on ----
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] nxt_free;

    assign nxt_free[STAGES-1] = m_ready;
    for (genvar k = 0; k < STAGES - 1; k++) begin : g_free
        assign nxt_free[k] = en[k+1];
    end
    assign en      = ~v_reg | nxt_free;
    assign s_ready = en[0];
    assign m_valid = v_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---- lane activity and IEEE special cases ----
    logic [31:0] comp [0:3];
    logic [2:0]  eff;
    logic [3:0]  act;
    logic        any_nan;
    logic        any_inf;
    side_t       side_in;

    assign comp[0] = s_comp_x;
    assign comp[1] = s_comp_y;
    assign comp[2] = s_comp_z;
    assign comp[3] = s_comp_w;

    always_comb begin
        // zero counts as one lane, anything too large saturates
        if (s_lane_count == 3'd0) begin
            eff = 3'd1;
        end else if (s_lane_count > 3'(MAX_LANES)) begin
            eff = 3'(MAX_LANES);
        end else begin
            eff = s_lane_count;
        end
        any_nan = 1'b0;
        any_inf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            act[i] = (3'(i) < eff);
            if (act[i] && comp[i][30:0] > INF_BITS[30:0]) begin
                any_nan = 1'b1;
            end
            if (act[i] && comp[i][30:0] == INF_BITS[30:0]) begin
                any_inf = 1'b1;
            end
        end
        side_in.act = act[3:1];
        priority if (any_nan) begin
            side_in.spec = SPEC_NAN;
        end else if (any_inf) begin
            side_in.spec = SPEC_INF;
        end else begin
            side_in.spec = SPEC_NONE;
        end
    end

    side_t side_reg [0:SIDE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= side_in;
        end
        for (int k = 1; k < SIDE_DEPTH; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---- squaring lanes, side by side ----
    dbl_t sq [0:3];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        fvl_lane u_lane (
            .aclk (aclk),
            .en   (en[0]),
            .comp (comp[i]),
            .sq   (sq[i])
        );
    end

    // later squares wait for the running sum to reach them
    dbl_t sq2_dly [1:2];
    dbl_t sq3_dly [1:4];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sq2_dly[1] <= sq[2];
            sq3_dly[1] <= sq[3];
        end
        if (en[2]) begin
            sq2_dly[2] <= sq2_dly[1];
            sq3_dly[2] <= sq3_dly[1];
        end
        if (en[3]) begin
            sq3_dly[3] <= sq3_dly[2];
        end
        if (en[4]) begin
            sq3_dly[4] <= sq3_dly[3];
        end
    end

    // ---- merge: in-order sum, rounded after each add ----
    dbl_t sum1;
    dbl_t sum2;
    dbl_t sum3;

    fvl_dadd u_add1 (
        .aclk  (aclk),
        .en_a  (en[1]),
        .en_b  (en[2]),
        .a     (sq[0]),
        .b     (sq[1]),
        .use_b (side_reg[0].act[1]),
        .y     (sum1)
    );

    fvl_dadd u_add2 (
        .aclk  (aclk),
        .en_a  (en[3]),
        .en_b  (en[4]),
        .a     (sum1),
        .b     (sq2_dly[2]),
        .use_b (side_reg[2].act[2]),
        .y     (sum2)
    );

    fvl_dadd u_add3 (
        .aclk  (aclk),
        .en_a  (en[5]),
        .en_b  (en[6]),
        .a     (sum2),
        .b     (sq3_dly[4]),
        .use_b (side_reg[4].act[3]),
        .y     (sum3)
    );

    // ---- binary32 rounding and square root ----
    fvl_root u_root (
        .aclk (aclk),
        .en   (en[STAGES-1:STAGES-ROOT_STAGES]),
        .x    (sum3),
        .spec (side_reg[SIDE_DEPTH-1].spec),
        .y    (m_length_bits)
    );

    // ---- checks ----
    a_empty_tail_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[STAGES-1] |-> s_ready)
        else $error("pipeline refuses items with an empty last stage");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("accepted item not held in the first stage");

    a_sign_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_length_bits[31])
        else $error("length has its sign bit set");

    a_nan_canonical: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_length_bits[30:23] == 8'hFF |->
            m_length_bits[22:0] == 23'd0 || m_length_bits[22:0] == 23'h400000)
        else $error("non-canonical NaN or infinity on the result");

endmodule

### tb/length_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_checker
// Watches both channels of float_vector_length, works out the binary32
// length of every accepted vector and compares it with the result stream.
// ----------------------------------------------------------------------------
module length_checker import fvl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_comp_x,
    input  logic [31:0] s_comp_y,
    input  logic [31:0] s_comp_z,
    input  logic [31:0] s_comp_w,
    input  logic [2:0]  s_lane_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_length_bits,
    output int          error_count,
    output int          pending_count,
    output int          checked_count
);

    logic [31:0] expected_lengths[$];

    initial begin
        error_count   = 0;
        checked_count = 0;
        pending_count = 0;
    end

    // binary32 magnitude widened exactly to a double
    function automatic real widen(input logic [31:0] mag);
        logic [23:0] sig;
        int          ex;
        logic [10:0] dexp;
        if (mag[30:0] == 31'd0) begin
            return 0.0;
        end
        if (mag[30:23] != 8'd0) begin
            sig = {1'b1, mag[22:0]};
            ex  = int'(mag[30:23]) - 127;
        end else begin
            sig = {1'b0, mag[22:0]};
            ex  = -126;
            while (!sig[23]) begin
                sig = sig << 1;
                ex--;
            end
        end
        dexp = 11'(ex + 1023);
        return $bitstoreal({1'b0, dexp, sig[22:0], 29'd0});
    endfunction

    // non-negative double to binary32, nearest-even, overflow to infinity
    function automatic logic [31:0] narrow(input real d);
        logic [63:0] b, sig, rem, half, mant;
        int          e, fe, sh;
        b = $realtobits(d);
        e = int'(b[62:52]);
        if (e == 0) begin
            return 32'd0;
        end
        sig = {11'd1, b[51:0]};
        fe  = e - 1023 + 127;
        if (fe >= 1) begin
            mant = sig >> 29;
            rem  = sig & ((64'd1 << 29) - 64'd1);
            half = 64'd1 << 28;
            if (rem > half || (rem == half && mant[0])) begin
                mant++;
            end
            if (mant[24]) begin
                mant = mant >> 1;
                fe++;
            end
            if (fe >= 255) begin
                return INF_BITS;
            end
            return {1'b0, fe[7:0], mant[22:0]};
        end
        if (fe < -40) begin
            return 32'd0;
        end
        sh = 30 - fe;
        if (sh > 63) begin
            return 32'd0;
        end
        mant = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && mant[0])) begin
            mant++;
        end
        return mant[31:0];
    endfunction

    // correctly rounded root of a non-negative binary32 value
    function automatic logic [31:0] root(input logic [31:0] f);
        logic [63:0] sig, n, res, bitv;
        int          ex, h;
        if (f[30:23] == 8'hFF) begin
            return f;
        end
        if (f[30:0] == 31'd0) begin
            return 32'd0;
        end
        if (f[30:23] != 8'd0) begin
            sig = {40'd1, f[22:0]};
            ex  = int'(f[30:23]) - 150;
        end else begin
            sig = {41'd0, f[22:0]};
            ex  = -149;
        end
        while (sig < 64'h80_0000) begin
            sig = sig << 1;
            ex--;
        end
        if (ex % 2 != 0) begin
            n  = sig << 23;
            ex = ex - 23;
        end else begin
            n  = sig << 24;
            ex = ex - 24;
        end
        res  = 64'd0;
        bitv = 64'd1 << 46;
        while (bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        h = ex / 2;
        if (n > res) begin
            res++;
        end
        if (res[24]) begin
            res = res >> 1;
            h++;
        end
        return {1'(0), 8'(h + 150), res[22:0]};
    endfunction

    function automatic logic [31:0] vector_length(input logic [31:0] c[4],
                                                  input logic [2:0] lanes_in);
        int  lanes;
        bit  any_nan, any_inf;
        real sum, dv;
        lanes   = (lanes_in == 3'd0) ? 1 : (lanes_in > MAX_LANES ? MAX_LANES : lanes_in);
        any_nan = 0;
        any_inf = 0;
        sum     = 0.0;
        for (int i = 0; i < lanes; i++) begin
            if ({1'b0, c[i][30:0]} > INF_BITS) any_nan = 1;
            else if ({1'b0, c[i][30:0]} == INF_BITS) any_inf = 1;
        end
        if (any_nan) return QNAN_BITS;
        if (any_inf) return INF_BITS;
        for (int i = 0; i < lanes; i++) begin
            dv  = widen({1'b0, c[i][30:0]});
            sum = sum + dv * dv;  // square is exact, each add rounds once
        end
        return root(narrow(sum));
    endfunction

    always @(posedge aclk) begin
        logic [31:0] c[4];
        logic [31:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c[0] = s_comp_x;
                c[1] = s_comp_y;
                c[2] = s_comp_z;
                c[3] = s_comp_w;
                expected_lengths.push_back(vector_length(c, s_lane_count));
            end
            if (m_valid && m_ready) begin
                if (expected_lengths.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_length_bits);
                    error_count++;
                end else begin
                    want = expected_lengths.pop_front();
                    checked_count++;
                    if (m_length_bits !== want) begin
                        $display("%0t: length_bits expected %h actual %h",
                                 $time, want, m_length_bits);
                        error_count++;
                    end
                end
            end
            pending_count = expected_lengths.size();
        end
    end

endmodule

### tb/tb_float_vector_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float_vector_length
// Drives vectors of binary32 components into float_vector_length with random
// gaps and result back-pressure; length_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_float_vector_length;
    import fvl_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_comp_x = '0;
    logic [31:0] s_comp_y = '0;
    logic [31:0] s_comp_z = '0;
    logic [31:0] s_comp_w = '0;
    logic [2:0]  s_lane_count = 3'd1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_length_bits;

    int  error_count, pending_count, checked_count;
    int  items_sent = 0;
    int  cycles = 0;
    bit  no_gaps = 0;       // stretch where neither side idles
    bit  hold_done = 0;

    float_vector_length DUT (.*);

    length_checker u_checker (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one item: optional idle gap, then hold valid until accepted
    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w,
                               input logic [2:0] lanes);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_comp_x     <= x;
        s_comp_y     <= y;
        s_comp_z     <= z;
        s_comp_w     <= w;
        s_lane_count <= lanes;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // mixes raw patterns, special values and components of matched scale
    function automatic logic [31:0] random_component(input int scale);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[30:0] = 31'h7F80_0000;                     // infinity
            1: v[30:23] = 8'hFF;                            // NaN (or inf)
            2: v[30:23] = 8'h00;                            // subnormal
            3: v[30:0] = 31'd0;                             // zero
            4: v[30:23] = 8'($urandom_range(230, 254));     // near overflow
            5, 6, 7: v[30:23] = 8'(scale + $urandom_range(0, 6) - 3);
            default: ;
        endcase
        return v;
    endfunction

    // result side: random stalls, plus one long hold to fill the pipeline
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (!hold_done && checked_count >= 400) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int          scale;
        logic [2:0]  lanes;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zeros, extremes, special values, lane count handling
        send_vector(32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0, 3'd4);
        send_vector(32'h4040_0000, 32'h4080_0000, 32'h0, 32'h0, 3'd2);   // 3,4 -> 5
        send_vector(32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 3'd4);
        send_vector(32'h7F7F_FFFF, 32'h0, 32'h0, 32'h0, 3'd1);           // sum overflows
        send_vector(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 3'd4);
        send_vector(32'h5F7F_FFFF, 32'h5F7F_FFFF, 32'h0, 32'h0, 3'd2);   // near the edge
        send_vector(32'h7F80_0000, 32'h3F80_0000, 32'h0, 32'h0, 3'd2);   // +inf
        send_vector(32'h3F80_0000, 32'hFF80_0000, 32'h0, 32'h0, 3'd2);   // -inf
        send_vector(32'h7FC0_0000, 32'h0, 32'h0, 32'h0, 3'd1);           // quiet NaN
        send_vector(32'hFF80_0001, 32'h7F80_0000, 32'h0, 32'h0, 3'd2);   // NaN beats inf
        send_vector(32'h0000_0001, 32'h8000_0001, 32'h0000_0001, 32'h0000_0001, 3'd4);
        send_vector(32'h0080_0000, 32'h0, 32'h0, 32'h0, 3'd1);           // smallest normal
        send_vector(32'h1F80_0000, 32'h1F80_0000, 32'h0, 32'h0, 3'd2);   // subnormal sum
        send_vector(32'h2000_0000, 32'h0, 32'h0, 32'h0, 3'd1);
        send_vector(32'h007F_FFFF, 32'h807F_FFFF, 32'h0, 32'h0, 3'd2);
        send_vector(32'h4000_0000, 32'h7FC0_0000, 32'h7F80_0000, 32'h0, 3'd1); // inactive
        send_vector(32'h4000_0000, 32'h0, 32'h0, 32'h0, 3'd0);           // zero lanes
        send_vector(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 3'd5);
        send_vector(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 3'd7);
        send_vector(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7FFF_FFFF, 3'd3);
        send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd6);
        send_vector(32'h3F80_0001, 32'h3F80_0001, 32'h3F80_0001, 32'h3F80_0001, 3'd4);

        // random vectors; a middle stretch runs with no gaps at all
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_gaps = (i >= 1000 && i < 1200);
            scale   = $urandom_range(3, 252);
            lanes   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 4));
            send_vector(random_component(scale), random_component(scale),
                        random_component(scale), random_component(scale), lanes);
        end
        s_valid <= 1'b0;

        wait (pending_count == 0);
        repeat (40) @(posedge aclk);
        $display("sent %0d vectors (directed specials and random lanes 0..7)", items_sent);
        $display("checked %0d lengths, %0d mismatches", checked_count, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/fvl_pkg.sv
rtl/core/fvl_lane.sv
rtl/core/fvl_dadd.sv
rtl/core/fvl_root.sv
rtl/core/float_vector_length.sv
tb/length_checker.sv
tb/tb_float_vector_length.sv
